// ===== design/assert_macros.svh =====
// Assertion macros shared by the depth bucket order table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DBOT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DBOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DBOT_ASSERT_NOW(label, ante, cons, msg)
`define DBOT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== design/dbot_pkg.sv =====
// Package with the constants, codes and control types of the depth bucket order table.
package dbot_pkg;

    localparam int BUCKETS      = 512;
    localparam int POOL_ENTRIES = 1024;

    localparam int OP_W    = 2;
    localparam int DEPTH_W = 9;
    localparam int IDX_W   = $clog2(POOL_ENTRIES);
    localparam int HEAD_AW = $clog2(BUCKETS);
    localparam int SCAN_W  = $clog2(BUCKETS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_RESET  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_WR,
        S_POP,
        S_SCAN_CHK,
        S_WALK_OUT,
        S_HEAD_OUT,
        S_MISC_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic ins_commit;
        logic pop_begin;
        logic scan_step;
        logic head_take;
        logic walk_out;
        logic head_out;
        logic done_out;
        logic misc_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic walk_nz;
        logic scan_nz;
        logic head_nz;
        logic scan_left;
        logic out_free;
    } sts_t;

endpackage

// ===== design/dbot_req_if.sv =====
// Request channel of the depth bucket order table.
interface dbot_req_if;
    logic                          valid;
    logic                          ready;
    logic [dbot_pkg::OP_W-1:0]     operation;
    logic [dbot_pkg::DEPTH_W-1:0]  depth;

    modport source (output valid, output operation, output depth, input ready);
    modport sink   (input valid, input operation, input depth, output ready);
endinterface

// ===== design/dbot_res_if.sv =====
// Result channel of the depth bucket order table.
interface dbot_res_if;
    logic                        valid;
    logic                        ready;
    logic [dbot_pkg::IDX_W-1:0]  entry_index;
    logic                        done_res;
    logic                        error;

    modport source (output valid, output entry_index, output done_res, output error,
                    input ready);
    modport sink   (input valid, input entry_index, input done_res, input error,
                    output ready);
endinterface

// ===== design/depth_bucket_order_table_unit.sv =====
// Top level of the depth bucket order table: controller, datapath and channel wiring.
// Insert: accepted in S_IDLE; S_INS_WR then registers its result.
// Pop that follows a list: S_POP, then S_WALK_OUT. Pop that moves to a new bucket: S_POP, then
// S_SCAN_CHK, which reads the next head for each empty bucket scanned, since the head memory has
// one read port, then S_HEAD_OUT. Allocator reset and unknown operations go through S_MISC_OUT.
// A result waiting on the output stalls only the final state of the next request. After
// power-on reset, S_CLEAR clears the heads while no request is accepted.
module depth_bucket_order_table_unit (
    input  logic       clk,
    input  logic       rst_n,
    dbot_req_if.sink   req,
    dbot_res_if.source res
);

    // The controller sequences each request in its state register; the datapath owns all other state.
    dbot_pkg::cmd_t cmd;
    dbot_pkg::sts_t sts;

    dbot_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_ready     (req.ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // The datapath holds the bucket heads, the entry links, the drain position and the
    // result register that separates the result channel from the request side.
    dbot_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_operation (req.operation),
        .req_depth     (req.depth),
        .res           (res)
    );

endmodule

// ===== design/dbot_datapath.sv =====
// Datapath of the depth bucket order table: head and link memories, drain state, result register.
`include "assert_macros.svh"

module dbot_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dbot_pkg::cmd_t                cmd,
    output dbot_pkg::sts_t                sts,
    input  logic [dbot_pkg::OP_W-1:0]     req_operation,
    input  logic [dbot_pkg::DEPTH_W-1:0]  req_depth,
    dbot_res_if.source                    res
);

    logic [dbot_pkg::IDX_W-1:0] head_mem [dbot_pkg::BUCKETS];
    logic [dbot_pkg::IDX_W-1:0] link_mem [dbot_pkg::POOL_ENTRIES];

    // Control state.
    logic [dbot_pkg::IDX_W-1:0]   alloc_count_reg, alloc_count_next;
    logic [dbot_pkg::DEPTH_W-1:0] deepest_reg, deepest_next;
    logic [dbot_pkg::SCAN_W-1:0]  scan_reg, scan_next;
    logic [dbot_pkg::IDX_W-1:0]   walk_reg, walk_next;
    logic                         draining_reg, draining_next;
    logic [dbot_pkg::HEAD_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic                         out_valid_reg, out_valid_next;

    // Payload state.
    dbot_pkg::op_t                op_reg, op_next;
    logic [dbot_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [dbot_pkg::IDX_W-1:0]   cur_reg, cur_next;
    logic [dbot_pkg::IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic                         res_done_reg, res_done_next;
    logic                         res_err_reg, res_err_next;
    logic [dbot_pkg::IDX_W-1:0]   head_rd_reg;
    logic [dbot_pkg::IDX_W-1:0]   link_rd_reg;

    // Memory ports.
    logic                         head_we, head_re;
    logic [dbot_pkg::HEAD_AW-1:0] head_waddr, head_raddr;
    logic [dbot_pkg::IDX_W-1:0]   head_wdata;
    logic                         link_we, link_re;
    logic [dbot_pkg::IDX_W-1:0]   link_waddr, link_raddr, link_wdata;

    logic [dbot_pkg::IDX_W-1:0]   eff_walk;
    logic [dbot_pkg::SCAN_W-1:0]  eff_scan, eff_scan_dec, scan_dec;
    logic [dbot_pkg::IDX_W-1:0]   new_idx;
    logic                         ins_err;
    logic                         commit;
    logic                         out_free;

    // A pop that opens a drain starts above the deepest bucket with no walk pending.
    assign eff_walk     = draining_reg ? walk_reg : '0;
    assign eff_scan     = draining_reg ? scan_reg
                        : dbot_pkg::SCAN_W'(deepest_reg) + dbot_pkg::SCAN_W'(1);
    assign eff_scan_dec = eff_scan - dbot_pkg::SCAN_W'(1);
    assign scan_dec     = scan_reg - dbot_pkg::SCAN_W'(1);
    assign new_idx      = alloc_count_reg + dbot_pkg::IDX_W'(1);
    assign ins_err      = (32'(depth_reg) >= 32'(dbot_pkg::BUCKETS))
                       || (alloc_count_reg >= dbot_pkg::IDX_W'(dbot_pkg::POOL_ENTRIES - 1));
    assign commit       = cmd.ins_commit || cmd.walk_out || cmd.head_out
                       || cmd.done_out || cmd.misc_out;
    assign out_free     = !out_valid_reg || res.ready;

    assign sts.clr_last  = (clr_cnt_reg == dbot_pkg::HEAD_AW'(dbot_pkg::BUCKETS - 1));
    assign sts.walk_nz   = (eff_walk != '0);
    assign sts.scan_nz   = (eff_scan != '0);
    assign sts.head_nz   = (head_rd_reg != '0);
    assign sts.scan_left = (scan_reg != '0);
    assign sts.out_free  = out_free;

    assign res.valid       = out_valid_reg;
    assign res.entry_index = res_idx_reg;
    assign res.done_res    = res_done_reg;
    assign res.error       = res_err_reg;

    // Memory port selection.
    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = clr_cnt_reg;
        head_wdata = '0;
        head_re    = 1'b0;
        head_raddr = dbot_pkg::HEAD_AW'(req_depth);
        link_we    = 1'b0;
        link_waddr = new_idx;
        link_wdata = head_rd_reg;
        link_re    = 1'b0;
        link_raddr = eff_walk;

        if (cmd.clr_wr)
        begin
            head_we = 1'b1;
        end
        if (cmd.accept)
        begin
            head_re = 1'b1;
        end
        if (cmd.ins_commit && !ins_err)
        begin
            head_we    = 1'b1;
            head_waddr = dbot_pkg::HEAD_AW'(depth_reg);
            head_wdata = new_idx;
            link_we    = 1'b1;
        end
        if (cmd.pop_begin)
        begin
            if (eff_walk != '0)
            begin
                link_re = 1'b1;
            end
            else
            begin
                head_re    = 1'b1;
                head_raddr = eff_scan_dec[dbot_pkg::HEAD_AW-1:0];
            end
        end
        if (cmd.scan_step)
        begin
            head_re    = 1'b1;
            head_raddr = scan_dec[dbot_pkg::HEAD_AW-1:0];
        end
        if (cmd.head_take)
        begin
            head_we    = 1'b1;
            head_waddr = scan_reg[dbot_pkg::HEAD_AW-1:0];
            head_wdata = '0;
            link_re    = 1'b1;
            link_raddr = head_rd_reg;
        end
    end

    // Next-state logic for clear counter, allocator, request capture, drain and result register.
    always_comb
    begin
        alloc_count_next = alloc_count_reg;
        deepest_next     = deepest_reg;
        scan_next        = scan_reg;
        walk_next        = walk_reg;
        draining_next    = draining_reg;
        clr_cnt_next     = clr_cnt_reg;
        op_next          = op_reg;
        depth_next       = depth_reg;
        cur_next         = cur_reg;
        res_idx_next     = res_idx_reg;
        res_done_next    = res_done_reg;
        res_err_next     = res_err_reg;
        out_valid_next   = commit ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

        if (cmd.clr_wr)
        begin
            clr_cnt_next = clr_cnt_reg + dbot_pkg::HEAD_AW'(1);
        end
        if (cmd.accept)
        begin
            op_next    = dbot_pkg::op_t'(req_operation);
            depth_next = req_depth;
        end
        if (cmd.ins_commit)
        begin
            res_done_next = 1'b0;
            res_err_next  = ins_err;
            res_idx_next  = ins_err ? '0 : new_idx;
            if (!ins_err)
            begin
                alloc_count_next = new_idx;
                if (depth_reg > deepest_reg)
                begin
                    deepest_next = depth_reg;
                end
            end
        end
        if (cmd.pop_begin)
        begin
            draining_next = 1'b1;
            walk_next     = eff_walk;
            if (eff_walk != '0 || eff_scan == '0)
            begin
                scan_next = eff_scan;
            end
            else
            begin
                scan_next = eff_scan_dec;
            end
        end
        if (cmd.scan_step)
        begin
            scan_next = scan_dec;
        end
        if (cmd.head_take)
        begin
            cur_next = head_rd_reg;
        end
        if (cmd.walk_out)
        begin
            res_idx_next  = walk_reg;
            res_done_next = 1'b0;
            res_err_next  = 1'b0;
            walk_next     = link_rd_reg;
        end
        if (cmd.head_out)
        begin
            res_idx_next  = cur_reg;
            res_done_next = 1'b0;
            res_err_next  = 1'b0;
            walk_next     = link_rd_reg;
        end
        if (cmd.done_out)
        begin
            res_idx_next  = '0;
            res_done_next = 1'b1;
            res_err_next  = 1'b0;
            draining_next = 1'b0;
        end
        if (cmd.misc_out)
        begin
            res_idx_next  = '0;
            res_done_next = 1'b0;
            res_err_next  = 1'b0;
            if (op_reg == dbot_pkg::OP_RESET)
            begin
                alloc_count_next = '0;
                deepest_next     = '0;
                scan_next        = '0;
                walk_next        = '0;
                draining_next    = 1'b0;
            end
            // A pop that finds neither a walk nor a bucket left ends the drain here.
            if (op_reg == dbot_pkg::OP_POP)
            begin
                res_done_next = 1'b1;
                draining_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re)
        begin
            head_rd_reg <= head_mem[head_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_count_reg <= '0;
            deepest_reg     <= '0;
            scan_reg        <= '0;
            walk_reg        <= '0;
            draining_reg    <= 1'b0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            alloc_count_reg <= alloc_count_next;
            deepest_reg     <= deepest_next;
            scan_reg        <= scan_next;
            walk_reg        <= walk_next;
            draining_reg    <= draining_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        depth_reg    <= depth_next;
        cur_reg      <= cur_next;
        res_idx_reg  <= res_idx_next;
        res_done_reg <= res_done_next;
        res_err_reg  <= res_err_next;
    end

    `DBOT_ASSERT_NOW(a_alloc_bound, 1'b1, alloc_count_reg <= dbot_pkg::IDX_W'(dbot_pkg::POOL_ENTRIES - 1), "allocator ran past the pool")
    `DBOT_ASSERT_NOW(a_walk_in_drain, walk_reg != '0, draining_reg, "walk pending outside a drain")
    `DBOT_ASSERT_NOW(a_done_clean, out_valid_reg && res_done_reg, res_idx_reg == '0 && !res_err_reg, "done result carries an index or error")

endmodule

// ===== design/dbot_ctrl.sv =====
// Controller state machine of the depth bucket order table.
`include "assert_macros.svh"

module dbot_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic [dbot_pkg::OP_W-1:0]  req_operation,
    output logic                       req_ready,
    input  dbot_pkg::sts_t             sts,
    output dbot_pkg::cmd_t             cmd
);

    dbot_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbot_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;

        case (state_reg)
            dbot_pkg::S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = dbot_pkg::S_IDLE;
                end
            end
            dbot_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    case (dbot_pkg::op_t'(req_operation))
                        dbot_pkg::OP_INSERT: state_next = dbot_pkg::S_INS_WR;
                        dbot_pkg::OP_POP:    state_next = dbot_pkg::S_POP;
                        default:             state_next = dbot_pkg::S_MISC_OUT;
                    endcase
                end
            end
            dbot_pkg::S_INS_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.ins_commit = 1'b1;
                    state_next     = dbot_pkg::S_IDLE;
                end
            end
            dbot_pkg::S_POP:
            begin
                cmd.pop_begin = 1'b1;
                if (sts.walk_nz)
                begin
                    state_next = dbot_pkg::S_WALK_OUT;
                end
                else if (sts.scan_nz)
                begin
                    state_next = dbot_pkg::S_SCAN_CHK;
                end
                else
                begin
                    state_next = dbot_pkg::S_MISC_OUT;
                end
            end
            dbot_pkg::S_SCAN_CHK:
            begin
                if (sts.head_nz)
                begin
                    cmd.head_take = 1'b1;
                    state_next    = dbot_pkg::S_HEAD_OUT;
                end
                else if (sts.scan_left)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.done_out = 1'b1;
                    state_next   = dbot_pkg::S_IDLE;
                end
            end
            dbot_pkg::S_WALK_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.walk_out = 1'b1;
                    state_next   = dbot_pkg::S_IDLE;
                end
            end
            dbot_pkg::S_HEAD_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.head_out = 1'b1;
                    state_next   = dbot_pkg::S_IDLE;
                end
            end
            dbot_pkg::S_MISC_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.misc_out = 1'b1;
                    state_next   = dbot_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dbot_pkg::S_IDLE;
            end
        endcase
    end

    `DBOT_ASSERT_NOW(a_commit_free, cmd.ins_commit || cmd.walk_out || cmd.head_out || cmd.done_out || cmd.misc_out, sts.out_free, "result committed over a waiting result")
    `DBOT_ASSERT_NEXT(a_accept_leaves_idle, cmd.accept, state_reg != dbot_pkg::S_IDLE && state_reg != dbot_pkg::S_CLEAR, "accepted request did not start work")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the depth bucket order table unit, with its own predictor.
`timescale 1ns / 1ps

module tb_top;
    import dbot_pkg::*;

    // The run is cut off at this many cycles. The worst correct run has every pop scan all
    // buckets and every request wait out the longest gap and stall, so this leaves a wide margin.
    localparam int CYCLE_LIMIT = 3_000_000;

    // The number of cycles to wait after the last result, so that a stray extra result is seen.
    localparam int SETTLE_CYCLES = 24;

    // One request waiting to be sent. When hold_for_results is set, the sender pauses before this
    // request until every result that is already expected has come back.
    typedef struct {
        op_t                op;
        logic [DEPTH_W-1:0] depth;
        bit                 hold_for_results;
    } table_request_t;

    // One result as the block should return it.
    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic             done_res;
        logic             error;
    } table_result_t;

    logic clk;
    logic rst_n;

    dbot_req_if req_ch ();
    dbot_res_if res_ch ();

    depth_bucket_order_table_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Requests still to be sent, and results still to come back, oldest first.
    table_request_t request_backlog[$];
    table_result_t  awaited_results[$];
    table_request_t in_flight;
    table_result_t  oldest_awaited;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    bit quiet_stretch  = 1'b0;

    // The predictor keeps its own copy of the ordering table. Each list is threaded through
    // next_in_bucket, and index 0 ends a list.
    logic [IDX_W-1:0]   bucket_first   [BUCKETS];
    logic [IDX_W-1:0]   next_in_bucket [POOL_ENTRIES];
    logic [IDX_W-1:0]   last_issued    = '0;
    logic [DEPTH_W-1:0] deepest_depth  = '0;
    logic [SCAN_W-1:0]  buckets_left   = '0;
    logic [IDX_W-1:0]   next_entry     = '0;
    logic               drain_active   = 1'b0;

    initial
    begin
        foreach (bucket_first[b])
        begin
            bucket_first[b] = '0;
        end
        foreach (next_in_bucket[e])
        begin
            next_in_bucket[e] = '0;
        end
    end

    // Applies one accepted request to the predicted table and returns the result it should give.
    function automatic table_result_t table_step(op_t op, logic [DEPTH_W-1:0] d);
        table_result_t    r;
        logic [IDX_W-1:0] e;
        bit               found;
        r = '0;
        found = 1'b0;
        case (op)
            OP_INSERT:
            begin
                // An insert into a full pool, or beyond the last bucket, is dropped whole.
                if (int'(d) >= BUCKETS || int'(last_issued) >= POOL_ENTRIES - 1)
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    last_issued = last_issued + 1'b1;
                    e = last_issued;
                    next_in_bucket[e] = bucket_first[d];
                    bucket_first[d] = e;
                    if (d > deepest_depth)
                    begin
                        deepest_depth = d;
                    end
                    r.entry_index = e;
                end
            end
            OP_POP:
            begin
                // The first pop after reset or after done starts a fresh scan from the top.
                if (!drain_active)
                begin
                    drain_active = 1'b1;
                    buckets_left = SCAN_W'(deepest_depth) + 1'b1;
                    next_entry = '0;
                end
                if (next_entry != '0)
                begin
                    r.entry_index = next_entry;
                    next_entry = next_in_bucket[next_entry];
                end
                else
                begin
                    while (buckets_left != '0 && !found)
                    begin
                        buckets_left = buckets_left - 1'b1;
                        if (bucket_first[buckets_left[HEAD_AW-1:0]] != '0)
                        begin
                            e = bucket_first[buckets_left[HEAD_AW-1:0]];
                            bucket_first[buckets_left[HEAD_AW-1:0]] = '0;
                            next_entry = next_in_bucket[e];
                            r.entry_index = e;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        drain_active = 1'b0;
                        r.done_res = 1'b1;
                    end
                end
            end
            OP_RESET:
            begin
                // The heads are kept; only the allocator and the drain restart.
                last_issued = '0;
                deepest_depth = '0;
                buckets_left = '0;
                next_entry = '0;
                drain_active = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Gaps and stalls are mostly short with a few long ones, and none at all in quiet stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_stretch || roll < 60)
        begin
            return 0;
        end
        else if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Depths lean toward a few low buckets so that lists get long, but span the whole range too.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        if ($urandom_range(0, 2) == 0)
        begin
            return DEPTH_W'($urandom_range(0, 7));
        end
        return DEPTH_W'($urandom_range(0, BUCKETS - 1));
    endfunction

    task automatic queue_request(op_t op, int d, bit hold = 1'b0);
        table_request_t item;
        item.op = op;
        item.depth = DEPTH_W'(d);
        item.hold_for_results = hold;
        request_backlog.push_back(item);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("tb_top: mismatch in %s: got %0d, expected %0d (cycle %0d)",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_NOP;
        req_ch.depth = '0;
        res_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always #4 clk = ~clk;

    // The cycle counter also flips between quiet stretches and stretches with idling, and stops
    // a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 384 == 0)
        begin
            quiet_stretch <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Request driver. A request is predicted at the edge where it is accepted, so expectations
    // line up with results in request order. A request held by a low ready stays as it is.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.operation <= OP_NOP;
            req_ch.depth <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                awaited_results.push_back(table_step(in_flight.op, in_flight.depth));
            end
            if (req_ch.valid && !req_ch.ready)
            begin
                // The current request is still waiting to be accepted.
            end
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (request_backlog.size() == 0 ||
                     (request_backlog[0].hold_for_results && awaited_results.size() != 0))
            begin
                req_ch.valid <= 1'b0;
            end
            else
            begin
                in_flight = request_backlog.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.operation <= in_flight.op;
                req_ch.depth <= in_flight.depth;
                send_gap <= pick_gap();
            end
        end
    end

    // Result monitor and ready driver. Every accepted result is matched against the oldest
    // expectation, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("unexpected result, entry_index", res_ch.entry_index, 0);
                end
                else
                begin
                    oldest_awaited = awaited_results.pop_front();
                    if (res_ch.entry_index !== oldest_awaited.entry_index)
                    begin
                        report_mismatch("entry_index", res_ch.entry_index,
                                        oldest_awaited.entry_index);
                    end
                    if (res_ch.done_res !== oldest_awaited.done_res)
                    begin
                        report_mismatch("done_res", res_ch.done_res, oldest_awaited.done_res);
                    end
                    if (res_ch.error !== oldest_awaited.error)
                    begin
                        report_mismatch("error", res_ch.error, oldest_awaited.error);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                begin
                    stall_left <= pick_gap();
                end
            end
        end
    end

    // Stimulus. The whole request list is built up front; the driver sends it as the block
    // accepts it.
    initial
    begin
        int session;
        int i;
        int roll;
        int inserts;
        int pops;

        // Directed part. A pop on an empty table reports done at once, and an unknown
        // operation is a no-op.
        queue_request(OP_POP, 0);
        queue_request(OP_NOP, BUCKETS - 1);
        // Fill the lowest bucket, the highest bucket twice and two alternating bit patterns.
        queue_request(OP_INSERT, 0);
        queue_request(OP_INSERT, BUCKETS - 1);
        queue_request(OP_INSERT, BUCKETS - 1);
        queue_request(OP_INSERT, 'h155);
        queue_request(OP_INSERT, 'h0AA);
        // The drain starts at the top bucket with its newest entry. An insert into a bucket
        // already passed waits for the next drain; one into a bucket still ahead is returned.
        queue_request(OP_POP, 0);
        queue_request(OP_INSERT, BUCKETS - 1);
        queue_request(OP_POP, 0);
        queue_request(OP_INSERT, 3);
        repeat (5) queue_request(OP_POP, 0);
        queue_request(OP_POP, 0);
        // The pop above, the first after done, starts a new scan and finds the late insert; this one reports done.
        queue_request(OP_POP, 0);
        // Reset ignores its depth, restarts the allocator and abandons the drain.
        queue_request(OP_RESET, BUCKETS - 1);
        queue_request(OP_INSERT, 2);
        queue_request(OP_POP, 0);
        queue_request(OP_POP, 0);
        queue_request(OP_NOP, 0);

        // Short sessions: a few inserts, then a drain that mostly runs to done and back,
        // sometimes stops early so that stale lists survive a reset. Stray inserts, resets and
        // unknown operations are mixed into the drains.
        for (session = 0; session < 8; session++)
        begin
            if (session == 0 || $urandom_range(0, 2) == 0)
            begin
                queue_request(OP_RESET, $urandom_range(0, BUCKETS - 1), session == 0);
            end
            inserts = $urandom_range(1, 8);
            for (i = 0; i < inserts; i++)
            begin
                queue_request(OP_INSERT, pick_depth());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                pops = $urandom_range(0, inserts);
            end
            else
            begin
                pops = inserts + $urandom_range(1, 3);
            end
            for (i = 0; i < pops; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 12)
                begin
                    queue_request(OP_INSERT, pick_depth());
                end
                else if (roll < 16)
                begin
                    queue_request(OP_NOP, $urandom_range(0, BUCKETS - 1));
                end
                else if (roll < 19)
                begin
                    queue_request(OP_RESET, $urandom_range(0, BUCKETS - 1));
                end
                queue_request(OP_POP, 0);
            end
        end

        // Long fill: the pool runs full and the last few inserts are dropped. Pops along the
        // way drain what is there and start again.
        queue_request(OP_RESET, 0, 1'b1);
        inserts = 0;
        while (inserts < POOL_ENTRIES + 4)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 94)
            begin
                queue_request(OP_INSERT, pick_depth());
                inserts++;
            end
            else if (roll < 98)
            begin
                queue_request(OP_POP, 0);
            end
            else
            begin
                queue_request(OP_NOP, $urandom_range(0, BUCKETS - 1));
            end
        end
        repeat (30) queue_request(OP_POP, 0);
        queue_request(OP_RESET, $urandom_range(0, BUCKETS - 1));
        repeat (4) queue_request(OP_POP, 0);

        // Wait for every request to go out and every result to return, then a short settle.
        while (request_backlog.size() != 0 || req_ch.valid !== 1'b0 ||
               awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
